// File: rtl/rrs_pkg.sv
// Package for the request retry scheduler: beat structs, table entry layout,
// queue control struct, request codes and sequencer states. No dependencies.
`default_nettype none

package rrs_pkg;

  localparam logic [1:0] REQ_SET     = 2'd0;
  localparam logic [1:0] REQ_CLEAR   = 2'd1;
  localparam logic [1:0] REQ_SERVICE = 2'd2;

  localparam logic [7:0] RETRY_FOREVER      = 8'd255;
  localparam logic [7:0] POP_INTERVAL_RESET = 8'd6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  target_index;
    logic [31:0] task_bits;
    logic [7:0]  retry_count;
    logic [31:0] repeat_interval;
    logic [31:0] now_time;
  } in_beat_t;

  typedef struct packed {
    logic        task_valid;
    logic [2:0]  popped_index;
    logic [31:0] popped_task;
    logic [31:0] waiting_mask;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] task_bits;
    logic [2:0]  index;
    logic [7:0]  retry;
    logic [31:0] last_time;
    logic [31:0] interval;
  } ent_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] task_bits;
  } q_item_t;

  typedef struct packed {
    logic    push;
    logic    pop;
    q_item_t item;
  } q_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POST,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: rtl/rrs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rrs_queue.sv
// Task FIFO: ring of DEPTH cells holding up to DEPTH-1 tasks, pointers in flops,
// cells in rrs_ram. Depends on rrs_pkg and rrs_ram.
`default_nettype none

module rrs_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rrs_pkg::q_ctrl_t ctrl,
  output logic                 empty,
  output rrs_pkg::q_item_t     rd_item
);

  localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [QW-1:0] rd_ptr_r;
  logic [QW-1:0] rd_ptr_nxt;
  logic [QW-1:0] wr_ptr_r;
  logic [QW-1:0] wr_ptr_nxt;
  logic [QW-1:0] wr_inc;
  logic [QW-1:0] rd_inc;
  logic          full;
  logic          do_push;
  logic [$bits(rrs_pkg::q_item_t)-1:0] rd_raw;

  assign wr_inc  = (wr_ptr_r == QW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc  = (rd_ptr_r == QW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign full    = (wr_inc == rd_ptr_r);
  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign do_push = ctrl.push && !full;
  assign wr_ptr_nxt = do_push ? wr_inc : wr_ptr_r;
  assign rd_ptr_nxt = ctrl.pop ? rd_inc : rd_ptr_r;
  assign rd_item    = rd_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  rrs_ram #(
    .WIDTH ($bits(rrs_pkg::q_item_t)),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (do_push),
    .waddr (wr_ptr_r),
    .wdata (ctrl.item),
    .re    (ctrl.pop),
    .raddr (rd_ptr_r),
    .rdata (rd_raw)
  );

endmodule

`default_nettype wire

// File: rtl/request_retry_scheduler_top.sv
// Request retry scheduler. An item is taken only while the block is idle. A set
// request, a clear request or a service pass sweeps the request table one entry
// per cycle through its RAM read port (read, modify, write back in the next cycle),
// so such an item passes through the scan, post and finish states before the next
// acceptance; any other item (set with retry or task zero, clear with task zero,
// index out of range, unused type) goes straight to the finish state. The result
// waits in an output register, so the next item is taken while it is stalled. Pops
// come from a task FIFO held in a second RAM; pushes to a full FIFO are dropped.
// Depends on rrs_pkg, rrs_ram and rrs_queue.
`default_nettype none

module request_retry_scheduler_top #(
  parameter int TABLE_ENTRIES = 32,
  parameter int INDEX_COUNT   = 8,
  parameter int QUEUE_DEPTH   = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rrs_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rrs_pkg::out_beat_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata
);

  localparam int TW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW       = TW + 1;
  localparam int WB_DEPTH = (INDEX_COUNT < 8) ? INDEX_COUNT : 8;

  rrs_pkg::state_t   state_r;
  rrs_pkg::state_t   state_nxt;
  rrs_pkg::in_beat_t req_r;
  logic              idx_ok_r;
  logic              in_acc;
  logic              idx_ok_in;
  logic              need_scan;

  logic [CW-1:0]     cnt_r;
  logic              s1_vld_r;
  logic [TW-1:0]     s1_addr_r;
  logic              free_fnd_r;
  logic [TW-1:0]     free_slot_r;
  logic              pend_r;
  logic [TABLE_ENTRIES-1:0] ent_vld_r;
  logic [31:0]       wb_r [WB_DEPTH];
  logic [31:0]       last_pop_r;
  logic [7:0]        pop_int_r;
  logic              pop_r;
  logic              out_valid_r;
  rrs_pkg::out_beat_t out_data_r;

  logic              tbl_re;
  logic [TW-1:0]     tbl_raddr;
  logic              tbl_we;
  logic [TW-1:0]     tbl_waddr;
  rrs_pkg::ent_t     tbl_wdata;
  logic [$bits(rrs_pkg::ent_t)-1:0] tbl_rraw;
  rrs_pkg::ent_t     rd;
  logic              e_vld;
  logic              e_match;
  logic              e_due;
  logic [7:0]        e_retry_nxt;
  logic              e_free;
  logic              svc_hit;
  logic              set_wr;
  logic              pop_due;
  logic              out_load;
  logic              out_free;
  rrs_pkg::q_ctrl_t  q_ctrl;
  logic              q_empty;
  rrs_pkg::q_item_t  q_item;
  rrs_pkg::out_beat_t res;
  logic [31:0]       sel_wb;

  assign in_acc    = in_valid && !in_stall;
  assign idx_ok_in = int'(in_data.target_index) < INDEX_COUNT;
  assign need_scan =
      (in_data.req_type == rrs_pkg::REQ_SET && idx_ok_in &&
       in_data.retry_count != 8'd0 && in_data.task_bits != 32'd0) ||
      (in_data.req_type == rrs_pkg::REQ_CLEAR && idx_ok_in &&
       in_data.task_bits != 32'd0) ||
      (in_data.req_type == rrs_pkg::REQ_SERVICE);

  assign rd      = tbl_rraw;
  assign e_vld   = s1_vld_r && ent_vld_r[s1_addr_r];
  assign e_match = e_vld && rd.index == req_r.target_index &&
                   rd.task_bits == req_r.task_bits;
  assign e_due   = (req_r.now_time - rd.last_time) >= rd.interval;
  assign e_retry_nxt = (rd.retry != rrs_pkg::RETRY_FOREVER && rd.retry != 8'd0) ?
                       rd.retry - 8'd1 : rd.retry;
  assign e_free  = rd.retry != rrs_pkg::RETRY_FOREVER && e_retry_nxt == 8'd0;
  assign svc_hit = state_r == rrs_pkg::ST_SCAN &&
                   req_r.req_type == rrs_pkg::REQ_SERVICE && e_vld && e_due;
  assign set_wr  = state_r == rrs_pkg::ST_POST && req_r.req_type == rrs_pkg::REQ_SET &&
                   !pend_r && free_fnd_r;
  assign pop_due = (req_r.now_time - last_pop_r) > {24'd0, pop_int_r};
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrs_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = need_scan ? rrs_pkg::ST_SCAN : rrs_pkg::ST_FINISH;
        end
      end
      rrs_pkg::ST_SCAN: begin
        if (cnt_r == CW'(TABLE_ENTRIES)) begin
          state_nxt = rrs_pkg::ST_POST;
        end
      end
      rrs_pkg::ST_POST: begin
        state_nxt = rrs_pkg::ST_FINISH;
      end
      rrs_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = rrs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rrs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = 1'b1;
    tbl_re    = 1'b0;
    tbl_raddr = cnt_r[TW-1:0];
    tbl_we    = 1'b0;
    tbl_waddr = s1_addr_r;
    tbl_wdata = rd;
    q_ctrl    = '0;
    out_load  = 1'b0;
    unique case (state_r)
      rrs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_data.req_type == rrs_pkg::REQ_SET && idx_ok_in) begin
          q_ctrl.push           = 1'b1;
          q_ctrl.item.index     = in_data.target_index;
          q_ctrl.item.task_bits = in_data.task_bits;
        end
      end
      rrs_pkg::ST_SCAN: begin
        tbl_re = cnt_r != CW'(TABLE_ENTRIES);
        if (svc_hit) begin
          tbl_we                = 1'b1;
          tbl_wdata.last_time   = req_r.now_time;
          tbl_wdata.retry       = e_retry_nxt;
          q_ctrl.push           = 1'b1;
          q_ctrl.item.index     = rd.index;
          q_ctrl.item.task_bits = rd.task_bits;
        end
      end
      rrs_pkg::ST_POST: begin
        if (set_wr) begin
          tbl_we              = 1'b1;
          tbl_waddr           = free_slot_r;
          tbl_wdata.task_bits = req_r.task_bits;
          tbl_wdata.index     = req_r.target_index;
          tbl_wdata.retry     = req_r.retry_count;
          tbl_wdata.last_time = req_r.now_time;
          tbl_wdata.interval  = req_r.repeat_interval;
        end
        q_ctrl.pop = req_r.req_type == rrs_pkg::REQ_SERVICE && pop_due && !q_empty;
      end
      rrs_pkg::ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    sel_wb = '0;
    for (int k = 0; k < WB_DEPTH; k++) begin
      if (req_r.target_index == 3'(k)) begin
        sel_wb = wb_r[k];
      end
    end
  end

  always_comb begin
    res.task_valid   = pop_r;
    res.popped_index = pop_r ? q_item.index : 3'd0;
    res.popped_task  = pop_r ? q_item.task_bits : 32'd0;
    res.waiting_mask = idx_ok_r ? sel_wb : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rrs_pkg::ST_IDLE;
      pop_int_r <= rrs_pkg::POP_INTERVAL_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        pop_int_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r    <= in_data;
      idx_ok_r <= idx_ok_in;
    end
    s1_addr_r <= tbl_raddr;
  end

  // sweep counter, read stage and set search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_vld_r   <= 1'b0;
      free_fnd_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      s1_vld_r <= tbl_re;
      if (in_acc) begin
        cnt_r      <= '0;
        free_fnd_r <= 1'b0;
        pend_r     <= 1'b0;
      end else begin
        if (tbl_re) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (s1_vld_r && req_r.req_type == rrs_pkg::REQ_SET) begin
          if (!e_vld && !free_fnd_r) begin
            free_fnd_r <= 1'b1;
          end
          if (e_match) begin
            pend_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && !e_vld && !free_fnd_r) begin
      free_slot_r <= s1_addr_r;
    end
  end

  // slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else begin
      if (state_r == rrs_pkg::ST_SCAN && req_r.req_type == rrs_pkg::REQ_CLEAR && e_match) begin
        ent_vld_r[s1_addr_r] <= 1'b0;
      end
      if (svc_hit && e_free) begin
        ent_vld_r[s1_addr_r] <= 1'b0;
      end
      if (set_wr) begin
        ent_vld_r[free_slot_r] <= 1'b1;
      end
    end
  end

  // waiting masks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WB_DEPTH; k++) begin
        wb_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < WB_DEPTH; k++) begin
        if (in_acc) begin
          if (in_data.req_type == rrs_pkg::REQ_SERVICE) begin
            wb_r[k] <= '0;
          end else if (in_data.req_type == rrs_pkg::REQ_SET && idx_ok_in &&
                       in_data.target_index == 3'(k)) begin
            wb_r[k] <= wb_r[k] | in_data.task_bits;
          end
        end else if (state_r == rrs_pkg::ST_SCAN && e_vld) begin
          if (req_r.req_type == rrs_pkg::REQ_CLEAR && e_match &&
              req_r.target_index == 3'(k)) begin
            wb_r[k] <= wb_r[k] & ~req_r.task_bits;
          end else if (req_r.req_type == rrs_pkg::REQ_SERVICE && rd.index == 3'(k)) begin
            wb_r[k] <= wb_r[k] | rd.task_bits;
          end
        end
      end
    end
  end

  // pop pacing and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pop_r  <= '0;
      pop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == rrs_pkg::ST_POST) begin
        pop_r <= q_ctrl.pop;
        if (req_r.req_type == rrs_pkg::REQ_SERVICE && pop_due) begin
          last_pop_r <= req_r.now_time;
        end
      end else if (in_acc) begin
        pop_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rrs_ram #(
    .WIDTH ($bits(rrs_pkg::ent_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rraw)
  );

  rrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (q_ctrl),
    .empty   (q_empty),
    .rd_item (q_item)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("beat accepted while a request is in progress");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctrl.pop |-> !q_empty)
    else $error("pop issued on an empty queue");

  a_task_only_on_service: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && req_r.req_type != rrs_pkg::REQ_SERVICE |-> !res.task_valid)
    else $error("popped task reported for a non-service request");

  a_slots_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rrs_pkg::ST_IDLE |=> $stable(ent_vld_r))
    else $error("slot occupancy changed outside a sweep");

endmodule

`default_nettype wire

// File: test/tb_request_retry_scheduler_top.sv
// Testbench for request_retry_scheduler_top: a queue-fed driver, a checking monitor and
// an in-bench model of the request table, waiting masks and task FIFO.
// Depends on rrs_pkg and the scheduler RTL.
module tb_request_retry_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrs_pkg::*;

  localparam int TABLE_ENTRIES = 32;
  localparam int INDEX_COUNT   = 8;
  localparam int QUEUE_DEPTH   = 16;
  localparam int SETTLE_CYCLES = 48;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef enum {MIX_ANY, MIX_FILL, MIX_DRAIN} mix_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  request_retry_scheduler_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .INDEX_COUNT(INDEX_COUNT),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  bit [31:0] slot_bits   [TABLE_ENTRIES];
  bit [2:0]  slot_index  [TABLE_ENTRIES];
  bit [7:0]  slot_retry  [TABLE_ENTRIES];
  bit [31:0] slot_last   [TABLE_ENTRIES];
  bit [31:0] slot_period [TABLE_ENTRIES];
  bit [31:0] waiting     [INDEX_COUNT];
  q_item_t   fifo_cells  [QUEUE_DEPTH];
  int        fifo_rd;
  int        fifo_wr;
  bit [31:0] last_pop;
  bit [7:0]  pop_gap = POP_INTERVAL_RESET;

  in_beat_t  req_backlog[$];
  out_beat_t due_results[$];
  in_beat_t  sticky_reqs[$];
  bit [31:0] mask_pool [6];
  bit [31:0] tick;
  bit        steady;
  int        errors;
  int        checked;
  int        pops_seen;
  int        type_seen [4];

  function automatic void fifo_push(bit [2:0] idx, bit [31:0] bits);
    int nxt;
    nxt = (fifo_wr + 1) % QUEUE_DEPTH;
    if (nxt != fifo_rd) begin
      fifo_cells[fifo_wr].index = idx;
      fifo_cells[fifo_wr].task_bits = bits;
      fifo_wr = nxt;
    end
  endfunction

  function automatic out_beat_t advance_schedule(in_beat_t b);
    out_beat_t r;
    int        free_slot;
    bit        dup;
    bit [31:0] age;
    r = '0;
    free_slot = -1;
    dup = 1'b0;
    case (b.req_type)
      REQ_SET: begin
        fifo_push(b.target_index, b.task_bits);
        waiting[b.target_index] |= b.task_bits;
        if (b.retry_count != 0 && b.task_bits != 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_bits[i] == 0) begin
              if (free_slot < 0) free_slot = i;
            end else if (slot_index[i] == b.target_index && slot_bits[i] == b.task_bits) begin
              dup = 1'b1;
            end
          end
          if (!dup && free_slot >= 0) begin
            slot_bits[free_slot]   = b.task_bits;
            slot_index[free_slot]  = b.target_index;
            slot_retry[free_slot]  = b.retry_count;
            slot_last[free_slot]   = b.now_time;
            slot_period[free_slot] = b.repeat_interval;
          end
        end
      end
      REQ_CLEAR: begin
        if (b.task_bits != 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_bits[i] != 0 && slot_index[i] == b.target_index &&
                slot_bits[i] == b.task_bits) begin
              slot_bits[i] = '0;
              waiting[b.target_index] &= ~b.task_bits;
            end
          end
        end
      end
      REQ_SERVICE: begin
        foreach (waiting[k]) waiting[k] = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot_bits[i] != 0) begin
            waiting[slot_index[i]] |= slot_bits[i];
            age = b.now_time - slot_last[i];
            if (age >= slot_period[i]) begin
              fifo_push(slot_index[i], slot_bits[i]);
              slot_last[i] = b.now_time;
              if (slot_retry[i] != RETRY_FOREVER) begin
                if (slot_retry[i] != 0) slot_retry[i] = slot_retry[i] - 8'd1;
                if (slot_retry[i] == 0) slot_bits[i] = '0;
              end
            end
          end
        end
        age = b.now_time - last_pop;
        if (age > 32'(pop_gap)) begin
          last_pop = b.now_time;
          if (fifo_rd != fifo_wr) begin
            r.task_valid   = 1'b1;
            r.popped_index = fifo_cells[fifo_rd].index;
            r.popped_task  = fifo_cells[fifo_rd].task_bits;
            fifo_rd = (fifo_rd + 1) % QUEUE_DEPTH;
          end
        end
      end
      default: ;
    endcase
    r.waiting_mask = waiting[b.target_index];
    return r;
  endfunction

  function automatic in_beat_t gen_item(mix_t mix);
    in_beat_t b;
    int       roll;
    int       r2;
    roll = $urandom_range(99);
    tick += $urandom_range(8);
    if ($urandom_range(99) < 2) tick = $urandom;
    b.target_index = 3'($urandom_range(7));
    r2 = $urandom_range(99);
    if (r2 < 70) b.task_bits = mask_pool[$urandom_range(5)];
    else if (r2 < 73) b.task_bits = '0;
    else if (r2 < 76) b.task_bits = '1;
    else b.task_bits = $urandom;
    r2 = $urandom_range(99);
    if (r2 < 25) b.retry_count = '0;
    else if (r2 < 65) b.retry_count = 8'($urandom_range(1, 4));
    else if (r2 < 80) b.retry_count = RETRY_FOREVER;
    else b.retry_count = 8'($urandom_range(255));
    r2 = $urandom_range(99);
    if (r2 < 20) b.repeat_interval = '0;
    else if (r2 < 80) b.repeat_interval = $urandom_range(1, 40);
    else if (r2 < 90) b.repeat_interval = $urandom_range(41, 600);
    else b.repeat_interval = $urandom;
    if (roll < 40) b.req_type = REQ_SET;
    else if (roll < 55) b.req_type = REQ_CLEAR;
    else if (roll < 95) b.req_type = REQ_SERVICE;
    else b.req_type = REQ_UNUSED;
    case (mix)
      MIX_FILL: begin
        if (roll < 80) begin
          b.req_type = REQ_SET;
          b.task_bits = 32'h1 << $urandom_range(31);
          b.retry_count = RETRY_FOREVER;
          b.repeat_interval = '1;
          sticky_reqs.push_back(b);
        end else begin
          b.req_type = REQ_SERVICE;
        end
      end
      MIX_DRAIN: begin
        if (sticky_reqs.size() != 0 && roll < 70) begin
          b = sticky_reqs.pop_front();
          b.req_type = REQ_CLEAR;
        end
      end
      default: ;
    endcase
    b.now_time = tick;
    return b;
  endfunction

  function automatic void queue_req(logic [1:0] kind, bit [2:0] idx, bit [31:0] bits,
                                    bit [7:0] retry, bit [31:0] period, bit [31:0] now);
    in_beat_t b;
    b.req_type = kind;
    b.target_index = idx;
    b.task_bits = bits;
    b.retry_count = retry;
    b.repeat_interval = period;
    b.now_time = now;
    req_backlog.push_back(b);
  endfunction

  task automatic drain_to_idle();
    while (req_backlog.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic start_phase(bit [7:0] gap);
    drain_to_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_we <= 1'b0;
    pop_gap = gap;
    foreach (mask_pool[k]) mask_pool[k] = (k < 3) ? 32'h1 << $urandom_range(31) : $urandom;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(advance_schedule(in_data));
        type_seen[in_data.req_type]++;
      end
      if (!in_valid || !in_stall) begin
        if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
          in_valid <= 1'b1;
          in_data <= req_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: expected no beat, got %p", $time, out_data);
        end else begin
          want = due_results.pop_front();
          checked++;
          if (want.task_valid) pops_seen++;
          if (out_data.task_valid !== want.task_valid ||
              out_data.popped_index !== want.popped_index ||
              out_data.popped_task !== want.popped_task ||
              out_data.waiting_mask !== want.waiting_mask) begin
            errors++;
            $display("%0t: expected valid=%0b idx=%0d task=%h wait=%h,",
                     $time, want.task_valid, want.popped_index, want.popped_task,
                     want.waiting_mask,
                     " got valid=%0b idx=%0d task=%h wait=%h",
                     out_data.task_valid, out_data.popped_index,
                     out_data.popped_task, out_data.waiting_mask);
          end
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 17);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (mask_pool[k]) mask_pool[k] = (k < 3) ? 32'h1 << $urandom_range(31) : $urandom;
    @(negedge clk);

    queue_req(REQ_SERVICE, 3'd0, 32'h0,        8'd0,          32'd0,        32'd0);
    queue_req(REQ_SERVICE, 3'd1, 32'h0,        8'd0,          32'd0,        32'd7);
    queue_req(REQ_SET,     3'd0, 32'h0,        8'd1,          32'd0,        32'd8);
    queue_req(REQ_SET,     3'd7, 32'hFFFFFFFF, RETRY_FOREVER, 32'd0,        32'd9);
    queue_req(REQ_SET,     3'd7, 32'hFFFFFFFF, RETRY_FOREVER, 32'd3,        32'd9);
    queue_req(REQ_SET,     3'd3, 32'h1,        8'd0,          32'd4,        32'd10);
    queue_req(REQ_SET,     3'd5, 32'h80000000, 8'd2,          32'd5,        32'd11);
    queue_req(REQ_UNUSED,  3'd7, 32'hA5A5A5A5, RETRY_FOREVER, 32'hFFFFFFFF, 32'd12);
    queue_req(REQ_SERVICE, 3'd7, 32'h0,        8'd0,          32'd0,        32'd20);
    queue_req(REQ_SERVICE, 3'd5, 32'h0,        8'd0,          32'd0,        32'd26);
    queue_req(REQ_SERVICE, 3'd5, 32'h0,        8'd0,          32'd0,        32'd27);
    queue_req(REQ_CLEAR,   3'd7, 32'h0,        8'd0,          32'd0,        32'd28);
    queue_req(REQ_CLEAR,   3'd2, 32'h5,        8'd0,          32'd0,        32'd28);
    queue_req(REQ_CLEAR,   3'd7, 32'hFFFFFFFF, 8'd0,          32'd0,        32'd29);
    queue_req(REQ_SET,     3'd6, 32'h0000FFFF, 8'd1,          32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_req(REQ_SERVICE, 3'd6, 32'h0,        8'd0,          32'd0,        32'hFFFFFFF0);
    queue_req(REQ_SERVICE, 3'd6, 32'h0,        8'd0,          32'd0,        32'hFFFFFFFE);
    queue_req(REQ_SERVICE, 3'd4, 32'h0,        8'd0,          32'd0,        32'd5);
    tick = 32'd100;

    start_phase(8'd0);
    repeat (350) req_backlog.push_back(gen_item(MIX_ANY));
    start_phase(8'd255);
    repeat (250) req_backlog.push_back(gen_item(MIX_ANY));
    start_phase(8'd1);
    repeat (120) req_backlog.push_back(gen_item(MIX_FILL));
    repeat (130) req_backlog.push_back(gen_item(MIX_DRAIN));
    start_phase(8'($urandom_range(2, 254)));
    steady = 1'b1;
    tick = 32'hFFFFF000;
    repeat (350) req_backlog.push_back(gen_item(MIX_ANY));
    drain_to_idle();
    steady = 1'b0;
    start_phase(8'd3);
    repeat (350) req_backlog.push_back(gen_item(MIX_ANY));
    start_phase(POP_INTERVAL_RESET);
    repeat (300) req_backlog.push_back(gen_item(MIX_ANY));

    drain_to_idle();
    if (due_results.size() != 0) errors++;
    $display("Covered %0d set, %0d clear, %0d service",
             type_seen[REQ_SET], type_seen[REQ_CLEAR], type_seen[REQ_SERVICE],
             " and %0d unused-type beats across six pop intervals.",
             type_seen[REQ_UNUSED]);
    $display("Checked %0d results, %0d with a popped task, %0d mismatches.",
             checked, pops_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
